// ----- hdl/dnsmttl_pkg.sv -----
// ----------------------------------------------------------------------------
// dnsmttl_pkg
// Shared types and constants of the DNS response minimum-TTL scanner.
// ----------------------------------------------------------------------------
package dnsmttl_pkg;

	localparam int unsigned LABEL_MAX = 63;
	localparam int unsigned FIXED_LEN = 4;
	localparam int unsigned TTL_BYTES = 4;
	localparam int unsigned HDR_LEN   = 12;

	localparam logic [31:0] TTL_NONE = '1;

	localparam logic [3:0] POS_QD_HI = 4'd4;
	localparam logic [3:0] POS_QD_LO = 4'd5;
	localparam logic [3:0] POS_AN_HI = 4'd6;
	localparam logic [3:0] POS_AN_LO = 4'd7;
	localparam logic [3:0] POS_NS_HI = 4'd8;
	localparam logic [3:0] POS_NS_LO = 4'd9;
	localparam logic [3:0] POS_AR_HI = 4'd10;
	localparam logic [3:0] POS_AR_LO = 4'd11;

	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_Q_NAME  = 4'd1,
		PH_Q_LABEL = 4'd2,
		PH_Q_TAIL  = 4'd3,
		PH_Q_END   = 4'd4,
		PH_R_NAME  = 4'd5,
		PH_R_LABEL = 4'd6,
		PH_R_FIXED = 4'd7,
		PH_R_TTL   = 4'd8,
		PH_R_RDHI  = 4'd9,
		PH_R_RDLO  = 4'd10,
		PH_R_RDATA = 4'd11,
		PH_DONE    = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		ST_FOUND = 2'd0,
		ST_EMPTY = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	typedef struct packed {
		logic [31:0] min_ttl;
		status_t     status;
	} result_t;

endpackage

// ----- hdl/dnsmttl_if.sv -----
// ----------------------------------------------------------------------------
// dnsmttl_msg_if / dnsmttl_res_if
// Valid/ready channels for message bytes and scan results.
// ----------------------------------------------------------------------------
interface dnsmttl_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsmttl_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] min_ttl;
	logic [1:0]  scan_status;

	modport source (output valid, output min_ttl, output scan_status, input ready);
	modport sink (input valid, input min_ttl, input scan_status, output ready);
endinterface

// ----- hdl/dnsmttl_parser.sv -----
// ----------------------------------------------------------------------------
// dnsmttl_parser
// Per-byte DNS message walker: header counts, names, TTL minimum, RDLENGTH.
// ----------------------------------------------------------------------------
module dnsmttl_parser import dnsmttl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       push,
	output result_t    result
);

	phase_t      phase_q, phase_d;
	logic [3:0]  pos_q, pos_d;
	logic [15:0] skip_q, skip_d;
	logic [15:0] qleft_q, qleft_d;
	logic [15:0] rleft_q, rleft_d;
	logic [31:0] ttl_q, ttl_d;
	logic [31:0] min_q, min_d;
	logic [7:0]  rdhi_q, rdhi_d;
	logic        seen_q, seen_d;
	logic [15:0] word;
	logic [15:0] skip_dec;
	logic        is_ptr;

	assign word     = {rdhi_q, data_byte};
	assign skip_dec = skip_q - 16'd1;
	assign is_ptr   = data_byte > 8'(LABEL_MAX);

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		skip_d  = skip_q;
		qleft_d = qleft_q;
		rleft_d = rleft_q;
		ttl_d   = ttl_q;
		min_d   = min_q;
		rdhi_d  = rdhi_q;
		seen_d  = seen_q;
		unique case (phase_q)
			PH_HDR: begin
				if (pos_q == POS_QD_HI || pos_q == POS_AN_HI ||
				    pos_q == POS_NS_HI || pos_q == POS_AR_HI) begin
					rdhi_d = data_byte;
				end else if (pos_q == POS_QD_LO) begin
					qleft_d = word;
				end else if (pos_q == POS_AN_LO || pos_q == POS_NS_LO ||
				             pos_q == POS_AR_LO) begin
					rleft_d = rleft_q + word;
				end
				if (pos_q == POS_AR_LO) begin
					if (qleft_d != '0)
						phase_d = PH_Q_NAME;
					else if (rleft_d != '0)
						phase_d = PH_R_NAME;
					else
						phase_d = PH_DONE;
				end
				if (pos_q < 4'(HDR_LEN))
					pos_d = pos_q + 4'd1;
			end
			PH_Q_NAME, PH_R_NAME: begin
				if (is_ptr) begin
					skip_d  = 16'(FIXED_LEN + 1);
					phase_d = (phase_q == PH_Q_NAME) ? PH_Q_TAIL : PH_R_FIXED;
				end else if (data_byte == 8'd0) begin
					skip_d  = 16'(FIXED_LEN);
					phase_d = (phase_q == PH_Q_NAME) ? PH_Q_TAIL : PH_R_FIXED;
				end else begin
					skip_d  = {8'd0, data_byte};
					phase_d = (phase_q == PH_Q_NAME) ? PH_Q_LABEL : PH_R_LABEL;
				end
			end
			PH_Q_LABEL: begin
				skip_d = skip_dec;
				if (skip_dec == '0)
					phase_d = PH_Q_NAME;
			end
			PH_Q_TAIL: begin
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					qleft_d = qleft_q - 16'd1;
					if (qleft_d != '0)
						phase_d = PH_Q_NAME;
					else
						phase_d = (rleft_q != '0) ? PH_R_NAME : PH_Q_END;
				end
			end
			PH_Q_END: begin
				phase_d = PH_DONE;
			end
			PH_R_LABEL: begin
				skip_d = skip_dec;
				if (skip_dec == '0)
					phase_d = PH_R_NAME;
			end
			PH_R_FIXED: begin
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					skip_d  = 16'(TTL_BYTES);
					ttl_d   = '0;
					phase_d = PH_R_TTL;
				end
			end
			PH_R_TTL: begin
				ttl_d  = {ttl_q[23:0], data_byte};
				skip_d = skip_dec;
				if (skip_dec == '0) begin
					if (ttl_d < min_q)
						min_d = ttl_d;
					seen_d  = 1'b1;
					phase_d = PH_R_RDHI;
				end
			end
			PH_R_RDHI: begin
				rdhi_d  = data_byte;
				phase_d = (rleft_q == 16'd1) ? PH_DONE : PH_R_RDLO;
			end
			PH_R_RDLO: begin
				rleft_d = rleft_q - 16'd1;
				skip_d  = word;
				phase_d = (word == '0) ? PH_R_NAME : PH_R_RDATA;
			end
			PH_R_RDATA: begin
				skip_d = skip_dec;
				if (skip_dec == '0)
					phase_d = PH_R_NAME;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push           = accept && last_byte;
		result.min_ttl = '0;
		if (phase_d != PH_DONE) begin
			result.status = ST_BAD;
		end else if (seen_d) begin
			result.status = ST_FOUND;
			if (min_d != TTL_NONE)
				result.min_ttl = min_d;
		end else begin
			result.status = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q   <= '0;
			skip_q  <= '0;
			qleft_q <= '0;
			rleft_q <= '0;
			ttl_q   <= '0;
			min_q   <= TTL_NONE;
			rdhi_q  <= '0;
			seen_q  <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q <= PH_HDR;
				pos_q   <= '0;
				skip_q  <= '0;
				qleft_q <= '0;
				rleft_q <= '0;
				ttl_q   <= '0;
				min_q   <= TTL_NONE;
				rdhi_q  <= '0;
				seen_q  <= 1'b0;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				skip_q  <= skip_d;
				qleft_q <= qleft_d;
				rleft_q <= rleft_d;
				ttl_q   <= ttl_d;
				min_q   <= min_d;
				rdhi_q  <= rdhi_d;
				seen_q  <= seen_d;
			end
		end
	end

endmodule

// ----- hdl/dns_response_min_ttl_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// dns_response_min_ttl_scanner_unit
// Scans a DNS response byte stream and reports the smallest record TTL.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | handshake
//  msg     | in  | data_byte[7:0], last_byte    | valid/ready
//  res     | out | min_ttl[31:0], scan_status   | valid/ready
//
//  One byte per cycle while msg.ready is high; results are registered.
//  The parser state registers update once per accepted byte.
//  A two-entry output buffer keeps bytes flowing while one result waits.
//  msg.ready drops only when both output entries are full.
//  Reset clears the parser to the header phase and empties the buffer.
// ----------------------------------------------------------------------------
module dns_response_min_ttl_scanner_unit import dnsmttl_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	dnsmttl_msg_if.sink  msg,
	dnsmttl_res_if.source res
);

	logic    accept;
	logic    push;
	logic    pop;
	result_t new_res;
	result_t out_q;
	result_t skid_q;
	logic    out_v_q;
	logic    skid_v_q;

	assign msg.ready = !skid_v_q;
	assign accept    = msg.valid && !skid_v_q;
	assign pop       = out_v_q && res.ready;

	dnsmttl_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (msg.data_byte),
		.last_byte (msg.last_byte),
		.push      (push),
		.result    (new_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			out_v_q  <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (!out_v_q) begin
			out_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= skid_v_q ? skid_q : new_res;
		end else if (!out_v_q) begin
			out_q <= new_res;
		end else if (push) begin
			skid_q <= new_res;
		end
	end

	assign res.valid       = out_v_q;
	assign res.min_ttl     = out_q.min_ttl;
	assign res.scan_status = out_q.status;

endmodule

// ----- hdl/dnsmttl_checker.sv -----
// ----------------------------------------------------------------------------
// dnsmttl_checker
// Port-level checks of the scanner, bound to the top level.
// ----------------------------------------------------------------------------
module dnsmttl_checker import dnsmttl_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic        msg_last,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_min_ttl,
	input logic [1:0]  res_status
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_min_ttl) && $stable(res_status))
		else $error("result changed while stalled");

	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(msg_valid && msg_ready && msg_last))
		else $error("result without a final byte");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_status == ST_FOUND || res_status == ST_EMPTY ||
		               res_status == ST_BAD))
		else $error("unknown scan status");

	a_ttl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_FOUND |-> res_min_ttl == '0)
		else $error("nonzero ttl without records");

endmodule

bind dns_response_min_ttl_scanner_unit dnsmttl_checker u_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.msg_valid   (msg.valid),
	.msg_ready   (msg.ready),
	.msg_last    (msg.last_byte),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_min_ttl (res.min_ttl),
	.res_status  (res.scan_status)
);

// ----- tb/dns_response_min_ttl_scanner_unit_test.sv -----
// ----------------------------------------------------------------------------
// dns_response_min_ttl_scanner_unit_test
// Feeds DNS response messages byte by byte into the minimum-TTL scanner and
// checks every scan result against a cycle-free model of the parser. A short
// directed set covers header, question, record and name corner cases; the
// rest are random messages, mostly well formed, some cut short, corrupted or
// pure garbage. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module dns_response_min_ttl_scanner_unit_test;
	import dnsmttl_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RANDOM_BYTES = 1200;
	localparam int unsigned MIN_MESSAGES = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} msg_byte_t;

	logic clk;
	logic arst_n;

	dnsmttl_msg_if msg();
	dnsmttl_res_if res();

	dns_response_min_ttl_scanner_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.res    (res)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	msg_byte_t   tx_bytes[$];
	logic [7:0]  frame[$];
	result_t     ttl_reports[$];

	int unsigned n_messages;
	int unsigned n_bytes;
	int unsigned n_results;
	int unsigned n_found;
	int unsigned n_empty;
	int unsigned n_bad;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	// scan model state
	phase_t      scan_ph;
	logic [3:0]  hdr_pos;
	logic [16:0] skip_cnt;
	logic [15:0] q_left;
	logic [15:0] rr_left;
	logic [31:0] ttl_acc;
	logic [31:0] ttl_low;
	logic [7:0]  hi_byte;
	bit          rr_seen;

	task automatic clear_scan();
		scan_ph  = PH_HDR;
		hdr_pos  = '0;
		skip_cnt = '0;
		q_left   = '0;
		rr_left  = '0;
		ttl_acc  = '0;
		ttl_low  = TTL_NONE;
		hi_byte  = '0;
		rr_seen  = 1'b0;
	endtask

	function automatic phase_t name_step(logic [7:0] b, phase_t label_ph, phase_t fixed_ph);
		if (b > LABEL_MAX) begin
			skip_cnt = 17'(1 + FIXED_LEN);
			return fixed_ph;
		end
		if (b == 8'd0) begin
			skip_cnt = 17'(FIXED_LEN);
			return fixed_ph;
		end
		skip_cnt = 17'(b);
		return label_ph;
	endfunction

	task automatic scan_item(logic [7:0] b, logic last);
		result_t r;
		case (scan_ph)
			PH_HDR: begin
				if (hdr_pos == POS_QD_HI || hdr_pos == POS_AN_HI ||
				    hdr_pos == POS_NS_HI || hdr_pos == POS_AR_HI) begin
					hi_byte = b;
				end else if (hdr_pos == POS_QD_LO) begin
					q_left = {hi_byte, b};
				end else if (hdr_pos == POS_AN_LO || hdr_pos == POS_NS_LO ||
				             hdr_pos == POS_AR_LO) begin
					rr_left = rr_left + {hi_byte, b};
				end
				if (hdr_pos == POS_AR_LO) begin
					if (q_left != 0)
						scan_ph = PH_Q_NAME;
					else if (rr_left != 0)
						scan_ph = PH_R_NAME;
					else
						scan_ph = PH_DONE;
				end
				if (hdr_pos < HDR_LEN)
					hdr_pos = hdr_pos + 4'd1;
			end
			PH_Q_NAME: scan_ph = name_step(b, PH_Q_LABEL, PH_Q_TAIL);
			PH_Q_LABEL: begin
				skip_cnt = skip_cnt - 17'd1;
				if (skip_cnt == 0)
					scan_ph = PH_Q_NAME;
			end
			PH_Q_TAIL: begin
				skip_cnt = skip_cnt - 17'd1;
				if (skip_cnt == 0) begin
					q_left = q_left - 16'd1;
					if (q_left != 0)
						scan_ph = PH_Q_NAME;
					else
						scan_ph = (rr_left != 0) ? PH_R_NAME : PH_Q_END;
				end
			end
			PH_Q_END: scan_ph = PH_DONE;
			PH_R_NAME: scan_ph = name_step(b, PH_R_LABEL, PH_R_FIXED);
			PH_R_LABEL: begin
				skip_cnt = skip_cnt - 17'd1;
				if (skip_cnt == 0)
					scan_ph = PH_R_NAME;
			end
			PH_R_FIXED: begin
				skip_cnt = skip_cnt - 17'd1;
				if (skip_cnt == 0) begin
					skip_cnt = 17'(TTL_BYTES);
					ttl_acc  = '0;
					scan_ph  = PH_R_TTL;
				end
			end
			PH_R_TTL: begin
				ttl_acc  = {ttl_acc[23:0], b};
				skip_cnt = skip_cnt - 17'd1;
				if (skip_cnt == 0) begin
					if (ttl_acc < ttl_low)
						ttl_low = ttl_acc;
					rr_seen = 1'b1;
					scan_ph = PH_R_RDHI;
				end
			end
			PH_R_RDHI: begin
				hi_byte = b;
				scan_ph = (rr_left == 16'd1) ? PH_DONE : PH_R_RDLO;
			end
			PH_R_RDLO: begin
				rr_left  = rr_left - 16'd1;
				skip_cnt = {1'b0, hi_byte, b};
				scan_ph  = (skip_cnt == 0) ? PH_R_NAME : PH_R_RDATA;
			end
			PH_R_RDATA: begin
				skip_cnt = skip_cnt - 17'd1;
				if (skip_cnt == 0)
					scan_ph = PH_R_NAME;
			end
			default: ;
		endcase
		if (last) begin
			r.min_ttl = '0;
			if (scan_ph != PH_DONE) begin
				r.status = ST_BAD;
			end else if (rr_seen) begin
				r.status = ST_FOUND;
				r.min_ttl = (ttl_low == TTL_NONE) ? 32'd0 : ttl_low;
			end else begin
				r.status = ST_EMPTY;
			end
			ttl_reports.push_back(r);
			clear_scan();
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH at cycle %0d, result %0d: %s: got %0h, want %0h",
			cycle_count, n_results, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_result(logic [31:0] got_ttl, logic [1:0] got_status);
		result_t want;
		if (ttl_reports.size() == 0) begin
			report_mismatch("result with no scan pending", got_ttl, 32'd0);
			return;
		end
		want = ttl_reports.pop_front();
		if (got_status !== want.status)
			report_mismatch("scan_status", 32'(got_status), 32'(want.status));
		if (got_ttl !== want.min_ttl)
			report_mismatch("min_ttl", got_ttl, want.min_ttl);
		case (want.status)
			ST_FOUND: n_found++;
			ST_EMPTY: n_empty++;
			default:  n_bad++;
		endcase
		n_results++;
	endtask

	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// byte driver
	int unsigned tx_gap;
	int unsigned tx_stretch;
	bit          tx_calm;
	msg_byte_t   tx_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg.valid     <= 1'b0;
			msg.data_byte <= '0;
			msg.last_byte <= 1'b0;
			tx_gap     = 0;
			tx_stretch = 0;
			tx_calm    = 1'b0;
		end else if (!msg.valid || msg.ready) begin
			if (tx_gap != 0 || tx_bytes.size() == 0) begin
				msg.valid <= 1'b0;
				if (tx_gap != 0)
					tx_gap--;
			end else begin
				tx_next = tx_bytes.pop_front();
				msg.valid     <= 1'b1;
				msg.data_byte <= tx_next.data;
				msg.last_byte <= tx_next.last;
				if (tx_stretch == 0) begin
					tx_stretch = $urandom_range(20, 150);
					tx_calm    = ($urandom_range(0, 3) == 0);
				end else begin
					tx_stretch--;
				end
				tx_gap = pick_gap(tx_calm);
			end
		end
	end

	// result sink: ready with random stalls
	int unsigned rx_stall;
	int unsigned rx_stretch;
	bit          rx_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			rx_stall   = 0;
			rx_stretch = 0;
			rx_calm    = 1'b0;
		end else if (rx_stall != 0) begin
			res.ready <= 1'b0;
			rx_stall--;
		end else begin
			res.ready <= 1'b1;
			if (rx_stretch == 0) begin
				rx_stretch = $urandom_range(50, 400);
				rx_calm    = ($urandom_range(0, 3) == 0);
			end else begin
				rx_stretch--;
			end
			rx_stall = pick_gap(rx_calm);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (msg.valid && msg.ready)
				scan_item(msg.data_byte, msg.last_byte);
			if (res.valid && res.ready)
				check_result(res.min_ttl, res.scan_status);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, ttl_reports.size());
			$display("dns_response_min_ttl_scanner_unit_test: FAIL");
			$finish;
		end
	end

	// message building
	task automatic put16(logic [15:0] v);
		frame.push_back(v[15:8]);
		frame.push_back(v[7:0]);
	endtask

	task automatic put32(logic [31:0] v);
		put16(v[31:16]);
		put16(v[15:0]);
	endtask

	task automatic add_header(logic [15:0] qd, logic [15:0] an, logic [15:0] ns,
	                          logic [15:0] ar);
		put16(16'($urandom));
		put16(16'($urandom));
		put16(qd);
		put16(an);
		put16(ns);
		put16(ar);
	endtask

	// len 0 picks a random label length; term 0 ends at the root, else a pointer
	task automatic add_name(int unsigned labels, int unsigned len, logic [7:0] term);
		int unsigned n;
		for (int unsigned i = 0; i < labels; i++) begin
			if (len != 0)
				n = len;
			else if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, LABEL_MAX);
			else
				n = $urandom_range(1, 8);
			frame.push_back(8'(n));
			repeat (n) frame.push_back(8'($urandom));
		end
		frame.push_back(term);
		if (term != 8'd0)
			frame.push_back(8'($urandom));
	endtask

	function automatic logic [7:0] rand_term();
		if ($urandom_range(0, 2) == 0)
			return 8'($urandom_range(LABEL_MAX + 1, 255));
		return 8'd0;
	endfunction

	function automatic logic [31:0] rand_ttl();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return TTL_NONE;
			2: return 32'($urandom_range(0, 600));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_rdlen();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(0, 300));
		return 16'($urandom_range(0, 6));
	endfunction

	task automatic add_rr_body(logic [31:0] ttl, logic [15:0] rdlen, int unsigned cap);
		put32($urandom);
		put32(ttl);
		put16(rdlen);
		repeat ((rdlen < cap) ? rdlen : cap) frame.push_back(8'($urandom));
	endtask

	task automatic add_record(logic [31:0] ttl, logic [15:0] rdlen, int unsigned cap);
		add_name($urandom_range(0, 2), 0, rand_term());
		add_rr_body(ttl, rdlen, cap);
	endtask

	task automatic add_question();
		add_name($urandom_range(0, 3), 0, rand_term());
		put32($urandom);
	endtask

	task automatic send_frame(int unsigned keep);
		msg_byte_t it;
		if (keep > frame.size())
			keep = frame.size();
		if (keep == 0)
			keep = 1;
		for (int unsigned i = 0; i < keep; i++) begin
			it.data = frame[i];
			it.last = (i == keep - 1);
			tx_bytes.push_back(it);
		end
		n_bytes += keep;
		n_messages++;
		frame.delete();
	endtask

	task automatic make_message();
		int unsigned mode;
		int unsigned nq;
		int unsigned nrec;
		int unsigned an;
		int unsigned ns;
		mode = $urandom_range(0, 99);
		if (mode >= 95) begin
			repeat ($urandom_range(1, 40)) frame.push_back(8'($urandom));
			send_frame(frame.size());
			return;
		end
		nq   = $urandom_range(0, 2);
		nrec = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
		an   = $urandom_range(0, nrec);
		ns   = $urandom_range(0, nrec - an);
		add_header(16'(nq), 16'(an), 16'(ns), 16'(nrec - an - ns));
		repeat (nq) add_question();
		for (int unsigned i = 0; i < nrec; i++) begin
			if (i == nrec - 1)
				add_record(rand_ttl(), 16'($urandom), 4);
			else
				add_record(rand_ttl(), rand_rdlen(), 65535);
		end
		if (nrec == 0 && $urandom_range(0, 3) != 0)
			frame.push_back(8'($urandom));
		repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
		if (mode < 70) begin
			send_frame(frame.size());
		end else if (mode < 85) begin
			send_frame($urandom_range(1, frame.size()));
		end else begin
			frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
			send_frame(frame.size());
		end
	endtask

	task automatic build_directed();
		int unsigned sz;
		// header cut short
		add_header(1, 1, 0, 0);
		send_frame(1);
		add_header(1, 1, 0, 0);
		send_frame(HDR_LEN - 1);
		// no questions, no records
		add_header(0, 0, 0, 0);
		send_frame(HDR_LEN);
		add_header(0, 0, 0, 0);
		repeat (3) frame.push_back(8'($urandom));
		send_frame(frame.size());
		// questions only, with and without the byte after the last question
		add_header(1, 0, 0, 0);
		add_name(1, 3, 8'd0);
		put32($urandom);
		frame.push_back(8'($urandom));
		send_frame(frame.size());
		add_header(1, 0, 0, 0);
		add_name(1, 3, 8'd0);
		put32($urandom);
		send_frame(frame.size());
		// single record with zero TTL
		add_header(0, 1, 0, 0);
		add_record(32'd0, 4, 4);
		send_frame(frame.size());
		// every TTL all ones
		add_header(0, 2, 0, 0);
		add_record(TTL_NONE, 2, 2);
		add_record(TTL_NONE, 0, 0);
		send_frame(frame.size());
		// all sections, longest label, pointer bounds, long RDATA
		add_header(1, 1, 1, 1);
		add_name(1, LABEL_MAX, 8'(LABEL_MAX + 1));
		put32($urandom);
		add_name(0, 0, 8'hFF);
		add_rr_body(32'd300, 16'h012C, 16'h012C);
		add_name(2, 1, 8'd0);
		add_rr_body(32'd7, 16'd0, 0);
		add_name(0, 0, 8'd0);
		add_rr_body(32'h8000_0000, 16'hFFFF, 0);
		send_frame(frame.size());
		// record count sum wraps
		add_header(0, 16'hFFFF, 1, 0);
		send_frame(HDR_LEN);
		add_header(0, 16'hFFFF, 3, 0);
		add_record(32'd90, 3, 3);
		add_record(32'd40, 1, 1);
		send_frame(frame.size());
		// label runs past the end
		add_header(1, 0, 0, 0);
		add_name(1, LABEL_MAX, 8'd0);
		send_frame(HDR_LEN + 8);
		// ends inside RDLENGTH, then at a cut taken from the first message's size, while records remain
		add_header(0, 2, 0, 0);
		add_record(32'd50, 10, 10);
		sz = frame.size();
		send_frame(sz - 11);
		add_header(0, 2, 0, 0);
		add_record(32'd50, 10, 10);
		send_frame(sz - 3);
		// ends on last TTL byte, then on the first RDLENGTH byte
		add_header(0, 1, 0, 0);
		add_record(32'd5, 0, 0);
		send_frame(frame.size() - 2);
		add_header(0, 1, 0, 0);
		add_record(32'd5, 0, 0);
		send_frame(frame.size() - 1);
		// header of all ones
		repeat (HDR_LEN) frame.push_back(8'hFF);
		send_frame(frame.size());
	endtask

	initial begin
		int unsigned dir_bytes;
		arst_n = 1'b0;
		clear_scan();
		build_directed();
		dir_bytes = n_bytes;
		while (n_bytes < dir_bytes + RANDOM_BYTES || n_messages < MIN_MESSAGES)
			make_message();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (tx_bytes.size() != 0 || msg.valid || ttl_reports.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (ttl_reports.size() != 0)
			report_mismatch("results never delivered", ttl_reports.size(), 32'd0);
		$display("sent %0d messages in %0d bytes over %0d cycles", n_messages, n_bytes,
			cycle_count);
		$display("checked %0d results: %0d with TTL, %0d empty, %0d malformed; %0d mismatches",
			n_results, n_found, n_empty, n_bad, mismatch_count);
		if (mismatch_count == 0)
			$display("dns_response_min_ttl_scanner_unit_test: PASS");
		else
			$display("dns_response_min_ttl_scanner_unit_test: FAIL");
		$finish;
	end

endmodule
